### hw/rtl/multi_slot_oneshot_repeat_timer_bank_top_assert.svh
// assertion macros for the timer bank
// no dependencies; taken in by the top level with `include
`ifndef MULTI_SLOT_ONESHOT_REPEAT_TIMER_BANK_TOP_ASSERT_SVH
`define MULTI_SLOT_ONESHOT_REPEAT_TIMER_BANK_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MSTB_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mstb: same-cycle check failed");

// next-cycle implication, checked outside reset
`define MSTB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mstb: next-cycle check failed");

`endif

### hw/rtl/mstb_pkg.sv
// shared field widths and command codes for the timer bank
// no dependencies; used by the channel interfaces and the top level
package mstb_pkg;

   localparam int MODE_W   = 3;
   localparam int SLOT_W   = 4;
   localparam int PERIOD_W = 32;

   localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REG   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_REM   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_START = 3'd3;
   localparam logic [MODE_W-1:0] MODE_STOP  = 3'd4;

endpackage

### hw/rtl/mstb_req_if.sv
// command channel of the timer bank: valid/ready plus command fields
// depends on mstb_pkg
interface mstb_req_if import mstb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [SLOT_W-1:0]   slot;
   logic [PERIOD_W-1:0] period;
   logic                repeat_req;

   modport source (output valid, mode, slot, period, repeat_req, input ready);
   modport sink   (input valid, mode, slot, period, repeat_req, output ready);
endinterface

### hw/rtl/mstb_rsp_if.sv
// expiry channel of the timer bank: valid/ready plus expiry fields
// depends on mstb_pkg
interface mstb_rsp_if import mstb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] expired_slot;
   logic              last;

   modport source (output valid, expired_slot, last, input ready);
   modport sink   (input valid, expired_slot, last, output ready);
endinterface

### hw/rtl/multi_slot_oneshot_repeat_timer_bank_top.sv
// timer bank top level: slot flags, count memories, scan sequencer, expiry output
// depends on mstb_pkg, mstb_req_if, mstb_rsp_if and the assertion macro header
//
// usage
//  - req_chan carries one command item: tick, register, remove, start or stop
//  - rsp_chan carries one item per expired slot, in ascending slot order, with
//    last set on the final expiry of a tick; a tick with no expiry gives nothing
//  - a non-tick command leaves the sequencer idle, so req_chan stays ready
//  - a tick walks the slots one per cycle, unless the receiver stalls the scan,
//    through a single decrement/compare unit fed from the count memories: the
//    accept cycle, a scan of every slot and then the closing cycle
//  - req_chan.ready is low for the whole scan and the closing cycle
//  - an expiry is held one slot back so that last can be decided; if the
//    receiver stalls while a second expiry arrives the scan waits in place,
//    and the closing cycle waits until the held expiry can move out
//  - reset (synchronous, high) clears the active, running and repeat flags,
//    the sequencer and the output; the count memories are not cleared, a slot
//    only runs after a start has written both of its counts
`include "multi_slot_oneshot_repeat_timer_bank_top_assert.svh"

module multi_slot_oneshot_repeat_timer_bank_top
   import mstb_pkg::*;
#(
   parameter int NUM_SLOTS  = 16,
   parameter int COUNT_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   mstb_req_if.sink   req_chan,
   mstb_rsp_if.source rsp_chan
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
   localparam logic [PERIOD_W-1:0] CNT_MAX = PERIOD_W'((64'd1 << COUNT_BITS) - 64'd1);

   // sequencer codes
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [NUM_SLOTS-1:0] active_ff, active_in;
   logic [NUM_SLOTS-1:0] running_ff, running_in;
   logic [NUM_SLOTS-1:0] periodic_ff, periodic_in;

   // expiry held back one slot until we know whether another follows
   logic                 pend_vld_ff, pend_vld_in;
   logic [SLOT_W-1:0]    pend_slot_ff, pend_slot_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic                 rsp_last_ff, rsp_last_in;

   // count memories and their registered read data
   logic [COUNT_BITS-1:0] rem_mem_ff [NUM_SLOTS];
   logic [COUNT_BITS-1:0] rld_mem_ff [NUM_SLOTS];
   logic [COUNT_BITS-1:0] rem_q_ff;
   logic [COUNT_BITS-1:0] rld_q_ff;

   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic                  rem_we;
   logic [IDX_W-1:0]      rem_waddr;
   logic [COUNT_BITS-1:0] rem_wdata;
   logic                  rld_we;

   // command decode
   logic                  cmd_ok;
   logic [IDX_W-1:0]      cmd_idx;
   logic [PERIOD_W-1:0]   per_fix;
   logic [COUNT_BITS-1:0] start_cnt;

   // shared decrement and zero compare
   logic [COUNT_BITS-1:0] dec;
   logic                  hit;
   logic                  expire;
   logic                  rsp_free;
   logic                  stall;

   assign cmd_ok    = 32'(req_chan.slot) < NUM_SLOTS;
   assign cmd_idx   = IDX_W'(req_chan.slot);
   assign per_fix   = (req_chan.period == '0) ? PERIOD_W'(1) : req_chan.period;
   assign start_cnt = (per_fix > CNT_MAX) ? COUNT_BITS'(CNT_MAX) : COUNT_BITS'(per_fix);

   assign dec      = rem_q_ff - COUNT_BITS'(1);
   assign hit      = active_ff[idx_ff] && running_ff[idx_ff];
   assign expire   = (state_ff == ST_SCAN) && hit && (dec == '0);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   // a second expiry needs the held one moved out first
   assign stall    = expire && pend_vld_ff && !rsp_free;

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.expired_slot = rsp_slot_ff;
   assign rsp_chan.last         = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      active_in    = active_ff;
      running_in   = running_ff;
      periodic_in  = periodic_ff;
      pend_vld_in  = pend_vld_ff;
      pend_slot_in = pend_slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_last_in  = rsp_last_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff + IDX_W'(1);
      rem_we       = 1'b0;
      rem_waddr    = idx_ff;
      rem_wdata    = dec;
      rld_we       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.mode == MODE_TICK) begin
                  // prime the read of slot zero
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end else if (cmd_ok) begin
                  case (req_chan.mode)
                     MODE_REG: begin
                        if (!active_ff[cmd_idx]) begin
                           active_in[cmd_idx]  = 1'b1;
                           running_in[cmd_idx] = 1'b0;
                        end
                     end
                     MODE_REM: begin
                        active_in[cmd_idx] = 1'b0;
                     end
                     MODE_START: begin
                        if (active_ff[cmd_idx]) begin
                           rem_we               = 1'b1;
                           rem_waddr            = cmd_idx;
                           rem_wdata            = start_cnt;
                           rld_we               = 1'b1;
                           periodic_in[cmd_idx] = req_chan.repeat_req;
                           running_in[cmd_idx]  = 1'b1;
                        end
                     end
                     MODE_STOP: begin
                        running_in[cmd_idx] = 1'b0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               if (hit) begin
                  rem_we    = 1'b1;
                  rem_wdata = (expire && periodic_ff[idx_ff]) ? rld_q_ff : dec;
               end
               if (expire) begin
                  if (!periodic_ff[idx_ff]) begin
                     running_in[idx_ff] = 1'b0;
                  end
                  pend_vld_in  = 1'b1;
                  pend_slot_in = SLOT_W'(idx_ff);
                  if (pend_vld_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_slot_in  = pend_slot_ff;
                     rsp_last_in  = 1'b0;
                  end
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_FLUSH;
               end else begin
                  rd_en  = 1'b1;
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_vld_ff) begin
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = pend_slot_ff;
               rsp_last_in  = 1'b1;
               pend_vld_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         active_ff    <= '0;
         running_ff   <= '0;
         periodic_ff  <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         active_ff    <= active_in;
         running_ff   <= running_in;
         periodic_ff  <= periodic_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      pend_slot_ff <= pend_slot_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // count memories: one write and one registered read each per cycle
   always_ff @(posedge clock) begin
      if (rem_we) begin
         rem_mem_ff[rem_waddr] <= rem_wdata;
      end
      if (rld_we) begin
         rld_mem_ff[cmd_idx] <= start_cnt;
      end
      if (rd_en) begin
         rem_q_ff <= rem_mem_ff[rd_addr];
         rld_q_ff <= rld_mem_ff[rd_addr];
      end
   end

   `MSTB_ASSERT_NOW(a_idle_no_pend, clock, reset, state_ff == ST_IDLE, !pend_vld_ff)
   `MSTB_ASSERT_NOW(a_scan_idx_range, clock, reset, state_ff == ST_SCAN,
      32'(idx_ff) < NUM_SLOTS)
   `MSTB_ASSERT_NEXT(a_stall_holds_idx, clock, reset, stall,
      (state_ff == ST_SCAN) && $stable(idx_ff))
   `MSTB_ASSERT_NEXT(a_flush_empty_idle, clock, reset,
      (state_ff == ST_FLUSH) && !pend_vld_ff, state_ff == ST_IDLE)

endmodule
